>>> hw/rtl/per_color_reachability_count_macros.svh
// Assertion shorthands, sampled on aclk and held off while aresetn is low.
`ifndef PER_COLOR_REACHABILITY_COUNT_MACROS_SVH
`define PER_COLOR_REACHABILITY_COUNT_MACROS_SVH

// Same-cycle implication.
`define PCRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pcrc: same-cycle check failed");

// Next-cycle implication.
`define PCRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pcrc: next-cycle check failed");

`endif

>>> hw/rtl/pcrc_pkg.sv
`default_nettype none

package pcrc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_COLORS   = 64;

    // Fixed field widths of the ports.
    localparam int FIELD_W = 7;
    localparam int CNT_W   = 7;

    // Vertex index, color index and adjacency memory geometry.
    localparam int VTX_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int COL_W  = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
    localparam int NCL_W  = $clog2(MAX_COLORS + 1);
    localparam int ADDR_W = COL_W + VTX_W;
    localparam int DEPTH  = 2 ** ADDR_W;

    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

    // Item kinds.
    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic REG_NUM_VERTICES = 1'b0;
    localparam logic REG_NUM_COLORS   = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WA,
        ST_ADD_WB,
        ST_SEED,
        ST_PICK,
        ST_MERGE,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/per_color_reachability_count.sv
// per_color_reachability_count: one undirected graph per edge color over vertices
// 1..64, colors 1..64. An add item (kind 0) sets the edge a-b in its color and
// returns nothing; endpoints or a color out of range drop the item. A query item
// (kind 1) returns how many colors 1..num_colors connect vertex_a to vertex_b,
// walking only into vertices 1..num_vertices; a equal to b counts every color.
// After reset the adjacency memory is swept clear, one row per cycle, over all
// 4096 rows before the first item is taken; configuration writes are taken at any
// time. One item is in flight at a time. An add reads row a, writes it back with
// bit b set while reading row b, then writes row b back with bit a set, through
// the adjacency memory's one read port and one write port. A query walks each
// counted color in turn: each reached vertex costs one row read and one merge of
// that row into the visited set. A query that starts on an invalid vertex, whose
// endpoints are equal, or that counts no colors answers without a walk. The result
// stays on m_connected_colors until taken.
`default_nettype none

`include "per_color_reachability_count_macros.svh"

module per_color_reachability_count (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_addr,
    input  wire logic [pcrc_pkg::FIELD_W-1:0]  cfg_wdata,
    // input items
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_kind,
    input  wire logic [pcrc_pkg::FIELD_W-1:0]  s_vertex_a,
    input  wire logic [pcrc_pkg::FIELD_W-1:0]  s_vertex_b,
    input  wire logic [pcrc_pkg::FIELD_W-1:0]  s_color,
    // result items
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [pcrc_pkg::CNT_W-1:0]    m_connected_colors
);

    localparam int NV = pcrc_pkg::MAX_VERTICES;

    pcrc_pkg::state_t state_reg, state_next;

    logic [pcrc_pkg::ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [pcrc_pkg::FIELD_W-1:0] cfg_nv_reg, cfg_nc_reg;
    logic [pcrc_pkg::VTX_W-1:0]   a_idx_reg, a_idx_next;
    logic [pcrc_pkg::VTX_W-1:0]   b_idx_reg, b_idx_next;
    logic                         b_ok_reg, b_ok_next;
    logic [pcrc_pkg::COL_W-1:0]   col_reg, col_next;
    logic [NV-1:0]                visited_reg, visited_next;
    logic [NV-1:0]                pending_reg, pending_next;
    logic [pcrc_pkg::CNT_W-1:0]   count_reg, count_next;

    logic                         ram_we;
    logic [pcrc_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [NV-1:0]                ram_wdata, ram_rdata;

    logic                         accept;
    logic                         a_ok, b_ok, c_ok;
    logic                         clr_last, col_last, walk_hit, shortcut;
    logic [pcrc_pkg::NCL_W-1:0]   nc_lim;
    logic [pcrc_pkg::CNT_W-1:0]   nc_cnt;
    logic [NV-1:0]                allowed_mask, new_bits;
    logic [pcrc_pkg::VTX_W-1:0]   pick_idx;

    pcrc_ram #(
        .DATA_W (NV),
        .DEPTH  (pcrc_pkg::DEPTH)
    ) u_adj_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign accept = s_valid && s_ready;

    // Classify the incoming item's fields.
    assign a_ok = (s_vertex_a != '0) && (int'(s_vertex_a) <= NV);
    assign b_ok = (s_vertex_b != '0) && (int'(s_vertex_b) <= NV);
    assign c_ok = (s_color != '0) && (int'(s_color) <= pcrc_pkg::MAX_COLORS);

    // Saturate the color limit; num_vertices saturates through the mask compare.
    assign nc_lim = (int'(cfg_nc_reg) > pcrc_pkg::MAX_COLORS)
                  ? pcrc_pkg::NCL_W'(pcrc_pkg::MAX_COLORS)
                  : pcrc_pkg::NCL_W'(cfg_nc_reg);
    assign nc_cnt = (int'(nc_lim) > int'(pcrc_pkg::CNT_SAT))
                  ? pcrc_pkg::CNT_SAT
                  : pcrc_pkg::CNT_W'(nc_lim);

    // Equal endpoints, a bad start or no colors settle the answer without a walk.
    assign shortcut = (s_vertex_a == s_vertex_b) || !a_ok || (nc_lim == '0);

    assign clr_last = (clr_addr_reg == {pcrc_pkg::ADDR_W{1'b1}});
    assign col_last = (int'(col_reg) + 1 >= int'(nc_lim));
    assign walk_hit = b_ok_reg && visited_reg[b_idx_reg];
    assign new_bits = ram_rdata & allowed_mask & ~visited_reg;

    always_comb begin
        for (int i = 0; i < NV; i++) begin
            allowed_mask[i] = (i < int'(cfg_nv_reg));
        end
    end

    // Lowest pending vertex goes next.
    always_comb begin
        pick_idx = '0;
        for (int i = NV - 1; i >= 0; i--) begin
            if (pending_reg[i]) begin
                pick_idx = pcrc_pkg::VTX_W'(i);
            end
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pcrc_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    state_next = pcrc_pkg::ST_IDLE;
                end
            end
            pcrc_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_kind == pcrc_pkg::KIND_ADD) begin
                        state_next = (a_ok && b_ok && c_ok) ? pcrc_pkg::ST_ADD_RD
                                                            : pcrc_pkg::ST_IDLE;
                    end else begin
                        state_next = shortcut ? pcrc_pkg::ST_OUT : pcrc_pkg::ST_SEED;
                    end
                end
            end
            pcrc_pkg::ST_ADD_RD: state_next = pcrc_pkg::ST_ADD_WA;
            pcrc_pkg::ST_ADD_WA: state_next = pcrc_pkg::ST_ADD_WB;
            pcrc_pkg::ST_ADD_WB: state_next = pcrc_pkg::ST_IDLE;
            pcrc_pkg::ST_SEED:   state_next = pcrc_pkg::ST_PICK;
            pcrc_pkg::ST_PICK: begin
                if (pending_reg != '0) begin
                    state_next = pcrc_pkg::ST_MERGE;
                end else begin
                    state_next = col_last ? pcrc_pkg::ST_OUT : pcrc_pkg::ST_SEED;
                end
            end
            pcrc_pkg::ST_MERGE:  state_next = pcrc_pkg::ST_PICK;
            pcrc_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = pcrc_pkg::ST_IDLE;
                end
            end
            default: state_next = pcrc_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        clr_addr_next = clr_addr_reg;
        a_idx_next    = a_idx_reg;
        b_idx_next    = b_idx_reg;
        b_ok_next     = b_ok_reg;
        col_next      = col_reg;
        visited_next  = visited_reg;
        pending_next  = pending_reg;
        count_next    = count_reg;
        ram_we        = 1'b0;
        ram_waddr     = {col_reg, a_idx_reg};
        ram_wdata     = ram_rdata;
        ram_raddr     = {col_reg, a_idx_reg};
        s_ready       = 1'b0;
        m_valid       = 1'b0;

        unique case (state_reg)
            pcrc_pkg::ST_CLEAR: begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            pcrc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    a_idx_next = pcrc_pkg::VTX_W'(s_vertex_a - 1'b1);
                    b_idx_next = pcrc_pkg::VTX_W'(s_vertex_b - 1'b1);
                    b_ok_next  = b_ok;
                    if (s_kind == pcrc_pkg::KIND_ADD) begin
                        col_next = pcrc_pkg::COL_W'(s_color - 1'b1);
                    end else begin
                        col_next   = '0;
                        count_next = (s_vertex_a == s_vertex_b) ? nc_cnt : '0;
                    end
                end
            end
            pcrc_pkg::ST_ADD_RD: begin
                // issue read of row a
                ram_raddr = {col_reg, a_idx_reg};
            end
            pcrc_pkg::ST_ADD_WA: begin
                ram_we               = 1'b1;
                ram_waddr            = {col_reg, a_idx_reg};
                ram_wdata            = ram_rdata;
                ram_wdata[b_idx_reg] = 1'b1;
                ram_raddr            = {col_reg, b_idx_reg};
            end
            pcrc_pkg::ST_ADD_WB: begin
                ram_we               = 1'b1;
                ram_waddr            = {col_reg, b_idx_reg};
                ram_wdata            = ram_rdata;
                ram_wdata[a_idx_reg] = 1'b1;
            end
            pcrc_pkg::ST_SEED: begin
                visited_next            = '0;
                visited_next[a_idx_reg] = 1'b1;
                pending_next            = '0;
                pending_next[a_idx_reg] = 1'b1;
            end
            pcrc_pkg::ST_PICK: begin
                if (pending_reg != '0) begin
                    pending_next[pick_idx] = 1'b0;
                    ram_raddr              = {col_reg, pick_idx};
                end else begin
                    if (walk_hit && (count_reg != pcrc_pkg::CNT_SAT)) begin
                        count_next = count_reg + 1'b1;
                    end
                    col_next = col_reg + 1'b1;
                end
            end
            pcrc_pkg::ST_MERGE: begin
                visited_next = visited_reg | new_bits;
                pending_next = pending_reg | new_bits;
            end
            pcrc_pkg::ST_OUT: begin
                m_valid = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    assign m_connected_colors = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pcrc_pkg::ST_CLEAR;
            clr_addr_reg <= '0;
            count_reg    <= '0;
            cfg_nv_reg   <= pcrc_pkg::FIELD_W'(pcrc_pkg::MAX_VERTICES);
            cfg_nc_reg   <= pcrc_pkg::FIELD_W'(pcrc_pkg::MAX_COLORS);
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            count_reg    <= count_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    pcrc_pkg::REG_NUM_VERTICES: cfg_nv_reg <= cfg_wdata;
                    pcrc_pkg::REG_NUM_COLORS:   cfg_nc_reg <= cfg_wdata;
                    default:                    cfg_nv_reg <= cfg_nv_reg;
                endcase
            end
        end
    end

    // Walk payload: always seeded before use.
    always_ff @(posedge aclk) begin
        a_idx_reg   <= a_idx_next;
        b_idx_reg   <= b_idx_next;
        b_ok_reg    <= b_ok_next;
        col_reg     <= col_next;
        visited_reg <= visited_next;
        pending_reg <= pending_next;
    end

    // One item at a time: never ready while a result is shown.
    `PCRC_ASSERT_NOW(a_ready_excl, s_ready, !m_valid)
    // A pending vertex is always already visited.
    `PCRC_ASSERT_NOW(a_pend_sub, state_reg == pcrc_pkg::ST_PICK, (pending_reg & ~visited_reg) == '0)
    // Merging never drops a visited vertex.
    `PCRC_ASSERT_NEXT(a_visit_grow, state_reg == pcrc_pkg::ST_MERGE, (visited_reg & $past(visited_reg)) == $past(visited_reg))
    // A picked vertex is always merged in the following cycle.
    `PCRC_ASSERT_NEXT(a_pick_merge, state_reg == pcrc_pkg::ST_PICK && pending_reg != '0, state_reg == pcrc_pkg::ST_MERGE)

endmodule

`default_nettype wire

>>> hw/rtl/pcrc_ram.sv
`default_nettype none

module pcrc_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Read returns the old contents on a same-address write.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> verif/per_color_reachability_count_test.sv
`default_nettype none

module per_color_reachability_count_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 10;
    // Cycles to let pass once the last result is in, so that a trailing add
    // (its read-modify-write of both rows) has finished before a register write.
    localparam int QUIET_CYCLES = 32;
    // Clear sweep, then about a dozen queries at 64 colors and about 120 random
    // items at small sizes, with random stalls on both sides. The limit covers
    // that several times over.
    localparam int unsigned CYCLE_LIMIT = 2_000_000;

    // Drive every block input from time zero; reset starts asserted.
    logic                           aclk       = 1'b0;
    logic                           aresetn    = 1'b0;
    logic                           cfg_wr_en  = 1'b0;
    logic                           cfg_addr   = pcrc_pkg::REG_NUM_VERTICES;
    logic [pcrc_pkg::FIELD_W-1:0]   cfg_wdata  = '0;
    logic                           s_valid    = 1'b0;
    logic                           s_ready;
    logic                           s_kind     = pcrc_pkg::KIND_ADD;
    logic [pcrc_pkg::FIELD_W-1:0]   s_vertex_a = '0;
    logic [pcrc_pkg::FIELD_W-1:0]   s_vertex_b = '0;
    logic [pcrc_pkg::FIELD_W-1:0]   s_color    = '0;
    logic                           m_valid;
    logic                           m_ready    = 1'b0;
    logic [pcrc_pkg::CNT_W-1:0]     m_connected_colors;

    per_color_reachability_count DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_kind             (s_kind),
        .s_vertex_a         (s_vertex_a),
        .s_vertex_b         (s_vertex_b),
        .s_color            (s_color),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_connected_colors (m_connected_colors)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor state: one adjacency row per (color, vertex), plus the two
    // registers as last written (raw 7-bit values, saturated where used).
    // ------------------------------------------------------------------
    logic [pcrc_pkg::MAX_VERTICES-1:0] link_rows [pcrc_pkg::MAX_COLORS][pcrc_pkg::MAX_VERTICES]
        = '{default: '0};
    logic [pcrc_pkg::FIELD_W-1:0] vertex_limit = pcrc_pkg::FIELD_W'(pcrc_pkg::MAX_VERTICES);
    logic [pcrc_pkg::FIELD_W-1:0] color_limit  = pcrc_pkg::FIELD_W'(pcrc_pkg::MAX_COLORS);

    // Answers of accepted queries, oldest first.
    logic [pcrc_pkg::CNT_W-1:0]   pending_counts [$];
    logic [pcrc_pkg::CNT_W-1:0]   wanted_count;

    int unsigned             failures       = 0;
    int unsigned             cycle_count    = 0;
    int unsigned             sender_idle_pct = 0;
    int unsigned             sink_stall_pct  = 0;

    // Store an edge in both directions; drop it if an endpoint or the color
    // falls outside the physical range.
    function automatic void record_edge(logic [pcrc_pkg::FIELD_W-1:0] va,
                                        logic [pcrc_pkg::FIELD_W-1:0] vb,
                                        logic [pcrc_pkg::FIELD_W-1:0] hue);
        if (va >= 1 && va <= pcrc_pkg::MAX_VERTICES &&
            vb >= 1 && vb <= pcrc_pkg::MAX_VERTICES &&
            hue >= 1 && hue <= pcrc_pkg::MAX_COLORS) begin
            link_rows[hue - 1][va - 1][vb - 1] = 1'b1;
            link_rows[hue - 1][vb - 1][va - 1] = 1'b1;
        end
    endfunction

    // Count the colors in which from_v reaches to_v. The start is always
    // visited (even above the vertex limit); only vertices up to the limit
    // are entered. Equal endpoints count in every color, valid or not.
    function automatic logic [pcrc_pkg::CNT_W-1:0] count_linking_colors(
        logic [pcrc_pkg::FIELD_W-1:0] from_v,
        logic [pcrc_pkg::FIELD_W-1:0] to_v);
        int unsigned                       usable_v;
        int unsigned                       usable_c;
        int unsigned                       hits;
        logic [pcrc_pkg::MAX_VERTICES-1:0] enterable;
        logic [pcrc_pkg::MAX_VERTICES-1:0] reached;
        logic [pcrc_pkg::MAX_VERTICES-1:0] frontier;
        logic [pcrc_pkg::MAX_VERTICES-1:0] fresh;
        logic                              hit;
        usable_v  = (vertex_limit > pcrc_pkg::MAX_VERTICES) ? pcrc_pkg::MAX_VERTICES
                                                            : vertex_limit;
        usable_c  = (color_limit > pcrc_pkg::MAX_COLORS) ? pcrc_pkg::MAX_COLORS
                                                         : color_limit;
        hits      = 0;
        enterable = '0;
        for (int v = 0; v < usable_v; v++) enterable[v] = 1'b1;
        for (int c = 0; c < usable_c; c++) begin
            hit = 1'b0;
            if (from_v == to_v) begin
                hit = 1'b1;
            end else if (from_v >= 1 && from_v <= pcrc_pkg::MAX_VERTICES) begin
                reached              = '0;
                reached[from_v - 1]  = 1'b1;
                frontier             = reached;
                // Expand the frontier until it runs dry; order does not matter.
                while (frontier != '0) begin
                    for (int v = 0; v < pcrc_pkg::MAX_VERTICES; v++) begin
                        if (frontier[v]) begin
                            frontier[v] = 1'b0;
                            fresh       = link_rows[c][v] & enterable & ~reached;
                            reached    |= fresh;
                            frontier   |= fresh;
                        end
                    end
                end
                if (to_v >= 1 && to_v <= pcrc_pkg::MAX_VERTICES) hit = reached[to_v - 1];
            end
            if (hit && hits < pcrc_pkg::CNT_SAT) hits++;
        end
        return pcrc_pkg::CNT_W'(hits);
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall at random, check every taken item against the
    // oldest pending answer.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_counts.size() == 0) begin
                $error("connected_colors: got %0d with no query pending", m_connected_colors);
                failures++;
            end else begin
                wanted_count = pending_counts.pop_front();
                if (m_connected_colors !== wanted_count) begin
                    $error("connected_colors: expected %0d, actual %0d",
                           wanted_count, m_connected_colors);
                    failures++;
                end
            end
        end
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** per_color_reachability_count: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. Every task starts and ends just after a rising edge.
    // ------------------------------------------------------------------

    // Offer one item and hold it until taken; predict at the accepting edge.
    // Leave valid high when no gap follows, so back-to-back items stream.
    task automatic send_item(input logic kind, input logic [pcrc_pkg::FIELD_W-1:0] va,
                             input logic [pcrc_pkg::FIELD_W-1:0] vb,
                             input logic [pcrc_pkg::FIELD_W-1:0] hue);
        s_valid    <= 1'b1;
        s_kind     <= kind;
        s_vertex_a <= va;
        s_vertex_b <= vb;
        s_color    <= hue;
        do @(posedge aclk); while (!s_ready);
        if (kind == pcrc_pkg::KIND_ADD) record_edge(va, vb, hue);
        else pending_counts.push_back(count_linking_colors(va, vb));
        if ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    // Drop valid, wait for every pending answer, then let a trailing add finish.
    task automatic wait_for_quiet();
        s_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // Write one register; call only while the block is quiet.
    task automatic write_register(input logic idx, input logic [pcrc_pkg::FIELD_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        if (idx == pcrc_pkg::REG_NUM_VERTICES) vertex_limit = value;
        else color_limit = value;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty graph at the reset settings: only equal endpoints connect.
    task automatic test_empty_graph();
        send_item(pcrc_pkg::KIND_QUERY, 7'd1, 7'd1, 7'd127);    // same vertex: all 64 colors
        send_item(pcrc_pkg::KIND_QUERY, 7'd1, 7'd64, 7'd0);     // nothing stored yet
        send_item(pcrc_pkg::KIND_QUERY, 7'd0, 7'd0, 7'd5);      // invalid but equal endpoints
        send_item(pcrc_pkg::KIND_QUERY, 7'd127, 7'd5, 7'd64);   // invalid start walks nothing
        send_item(pcrc_pkg::KIND_QUERY, 7'd64, 7'd127, 7'd1);   // invalid target never reached
    endtask

    // Edges at the field extremes, reversed endpoints, self loops and
    // several kinds of out-of-range add that must be dropped.
    task automatic test_edge_extremes();
        send_item(pcrc_pkg::KIND_ADD, 7'd1, 7'd64, 7'd1);
        send_item(pcrc_pkg::KIND_ADD, 7'd64, 7'd1, 7'd64);
        send_item(pcrc_pkg::KIND_ADD, 7'd10, 7'd11, 7'd0);      // color zero
        send_item(pcrc_pkg::KIND_ADD, 7'd10, 7'd11, 7'd65);     // color above range
        send_item(pcrc_pkg::KIND_ADD, 7'd0, 7'd11, 7'd2);       // vertex zero
        send_item(pcrc_pkg::KIND_ADD, 7'd10, 7'd127, 7'd127);   // vertex and color all ones
        send_item(pcrc_pkg::KIND_ADD, 7'd65, 7'd11, 7'd3);      // vertex above range
        send_item(pcrc_pkg::KIND_ADD, 7'd5, 7'd5, 7'd3);        // self loop
        send_item(pcrc_pkg::KIND_QUERY, 7'd1, 7'd64, 7'd0);
        send_item(pcrc_pkg::KIND_QUERY, 7'd10, 7'd11, 7'd0);
        send_item(pcrc_pkg::KIND_QUERY, 7'd64, 7'd1, 7'd127);
        send_item(pcrc_pkg::KIND_QUERY, 7'd5, 7'd6, 7'd3);
    endtask

    // Register extremes: zero, one, the maximum and values above it.
    task automatic test_register_limits();
        wait_for_quiet();
        write_register(pcrc_pkg::REG_NUM_VERTICES, 7'd0);       // walk enters no neighbor
        send_item(pcrc_pkg::KIND_QUERY, 7'd1, 7'd64, 7'd1);
        wait_for_quiet();
        write_register(pcrc_pkg::REG_NUM_VERTICES, 7'd127);     // saturates at the maximum
        write_register(pcrc_pkg::REG_NUM_COLORS, 7'd0);         // no color counted
        send_item(pcrc_pkg::KIND_QUERY, 7'd1, 7'd1, 7'd1);
        wait_for_quiet();
        write_register(pcrc_pkg::REG_NUM_COLORS, 7'd127);
        write_register(pcrc_pkg::REG_NUM_VERTICES, 7'd63);
        // Target above the limit is never entered; a start above it still walks.
        send_item(pcrc_pkg::KIND_QUERY, 7'd1, 7'd64, 7'd2);
        send_item(pcrc_pkg::KIND_QUERY, 7'd64, 7'd1, 7'd2);
        wait_for_quiet();
        write_register(pcrc_pkg::REG_NUM_VERTICES, 7'd1);
        write_register(pcrc_pkg::REG_NUM_COLORS, 7'd1);
        send_item(pcrc_pkg::KIND_QUERY, 7'd64, 7'd1, 7'd2);
        wait_for_quiet();
        write_register(pcrc_pkg::REG_NUM_VERTICES, 7'd64);
        write_register(pcrc_pkg::REG_NUM_COLORS, 7'd64);
        send_item(pcrc_pkg::KIND_QUERY, 7'd64, 7'd64, 7'd0);
    endtask

    // Random graphs over a small vertex window with few colors, so walks stay
    // short; a tenth of the items are unconstrained noise over full fields.
    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct,
                                       input int unsigned count);
        int unsigned                  span;
        int unsigned                  roll;
        logic [pcrc_pkg::FIELD_W-1:0] nv;
        logic [pcrc_pkg::FIELD_W-1:0] nc;
        wait_for_quiet();
        nv = pcrc_pkg::FIELD_W'($urandom_range(4, 20));
        nc = pcrc_pkg::FIELD_W'($urandom_range(2, 8));
        write_register(pcrc_pkg::REG_NUM_VERTICES, nv);
        write_register(pcrc_pkg::REG_NUM_COLORS, nc);
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        // Let some edges land a few vertices above the limit.
        span = nv + 3;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                send_item(1'($urandom_range(1)), pcrc_pkg::FIELD_W'($urandom_range(127)),
                          pcrc_pkg::FIELD_W'($urandom_range(127)),
                          pcrc_pkg::FIELD_W'($urandom_range(127)));
            end else if (roll < 55) begin
                send_item(pcrc_pkg::KIND_ADD, pcrc_pkg::FIELD_W'($urandom_range(1, span)),
                          pcrc_pkg::FIELD_W'($urandom_range(1, span)),
                          pcrc_pkg::FIELD_W'($urandom_range(1, nc + 1)));
            end else begin
                send_item(pcrc_pkg::KIND_QUERY, pcrc_pkg::FIELD_W'($urandom_range(1, span)),
                          pcrc_pkg::FIELD_W'($urandom_range(1, span)),
                          pcrc_pkg::FIELD_W'($urandom_range(127)));
            end
        end
    endtask

    initial begin
        // Hold reset asserted from time zero, then release it; the block then
        // sweeps its memory clear and raises s_ready on its own.
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_graph();
        test_edge_extremes();
        test_register_limits();
        test_random_traffic(0, 0, 29);
        test_random_traffic(51, 0, 29);
        test_random_traffic(0, 51, 29);
        test_random_traffic(31, 31, 29);

        wait_for_quiet();
        if (failures == 0) begin
            $display("** per_color_reachability_count: PASSED **");
        end else begin
            $display("** per_color_reachability_count: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
